// File: src/gstuc_pkg.sv
// Shared types, constants and the microcode table for the GPS-to-UTC calendar block.
// No dependencies; imported by gps_seconds_to_utc_calendar.
`default_nettype none

package gstuc_pkg;

  // Field widths of the stream items
  localparam int unsigned GPS_W   = 32;
  localparam int unsigned LEAP_W  = 7;
  localparam int unsigned IN_W    = 40;   // 39 bits of fields, padded to bytes
  localparam int unsigned OUT_W   = 48;   // 46 bits of fields, padded to bytes

  // Working widths
  localparam int unsigned ACC_W   = 33;   // UTC second count since 1 Jan 1980
  localparam int unsigned QUO_W   = 16;   // largest quotient is the day count
  localparam int unsigned DIVR_W  = 17;   // widest divisor (seconds per day)
  localparam int unsigned PC_W    = 4;
  localparam int unsigned RDIV_W  = 26;   // widest pre-shifted dividend (UTC seconds / 128)
  localparam int unsigned RMUL_W  = 27;   // widest reciprocal
  localparam int unsigned PROD_W  = RDIV_W + RMUL_W;

  // Offset from GPS to UTC seconds: base leap count plus five days
  localparam logic [ACC_W-1:0] UTC_OFFSET = ACC_W'(19 + 5 * 86400);
  localparam logic [7:0]       YEAR_BASE  = 8'(1980 - 1900);
  localparam logic [7:0]       YEAR_LIMIT = 8'd255;
  localparam logic [3:0]       MONTH_LAST = 4'd11;
  localparam logic [3:0]       MONTH_FEB  = 4'd1;
  localparam logic [2:0]       EPOCH_WDAY = 3'd2;   // 1 Jan 1980 was a Tuesday

  // Reciprocals: quotient = ((x >> pre) * mul) >> post, exact over each dividend range.
  // Day: 86400 = 128 * 675; hour: 3600 = 16 * 225; minute: 60 = 4 * 15; week: 7.
  localparam logic [RMUL_W-1:0] RECIP_DAY  = RMUL_W'(((64'd1 << 36) + 64'd674) / 64'd675);
  localparam logic [RMUL_W-1:0] RECIP_HOUR = RMUL_W'(((64'd1 << 21) + 64'd224) / 64'd225);
  localparam logic [RMUL_W-1:0] RECIP_MIN  = RMUL_W'(((64'd1 << 14) + 64'd14) / 64'd15);
  localparam logic [RMUL_W-1:0] RECIP_WEEK = RMUL_W'(((64'd1 << 19) + 64'd6) / 64'd7);

  typedef enum logic [3:0] {
    OP_QUOT      = 4'd0,   // quotient by reciprocal multiply
    OP_REM       = 4'd1,   // subtract quotient times divisor
    OP_SAVE_DAYS = 4'd2,
    OP_SAVE_HOUR = 4'd3,
    OP_SAVE_MIN  = 4'd4,
    OP_SAVE_WDAY = 4'd5,
    OP_YEAR      = 4'd6,   // peel one year
    OP_MONTH     = 4'd7,   // peel one month
    OP_DONE      = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    DV_DAY  = 2'd0,
    DV_HOUR = 2'd1,
    DV_MIN  = 2'd2,
    DV_WEEK = 2'd3
  } dsel_t;

  typedef struct packed {
    op_t             op;
    dsel_t           dsel;
    logic [PC_W-1:0] tgt;   // branch target while a loop step continues
  } ctrl_t;

  typedef struct packed {
    logic [2:0]        pre;
    logic [RMUL_W-1:0] mul;
    logic [5:0]        post;
  } recip_t;

  // Program addresses that loops branch back to
  localparam logic [PC_W-1:0] PC_START = 4'd0;
  localparam logic [PC_W-1:0] PC_YEAR  = 4'd12;
  localparam logic [PC_W-1:0] PC_MONTH = 4'd13;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = '{op: OP_DONE, dsel: DV_DAY, tgt: PC_START};
    case (pc)
      4'd0:  cw = '{op: OP_QUOT,      dsel: DV_DAY,  tgt: PC_START};
      4'd1:  cw = '{op: OP_REM,       dsel: DV_DAY,  tgt: PC_START};
      4'd2:  cw = '{op: OP_SAVE_DAYS, dsel: DV_DAY,  tgt: PC_START};
      4'd3:  cw = '{op: OP_QUOT,      dsel: DV_HOUR, tgt: PC_START};
      4'd4:  cw = '{op: OP_REM,       dsel: DV_HOUR, tgt: PC_START};
      4'd5:  cw = '{op: OP_SAVE_HOUR, dsel: DV_HOUR, tgt: PC_START};
      4'd6:  cw = '{op: OP_QUOT,      dsel: DV_MIN,  tgt: PC_START};
      4'd7:  cw = '{op: OP_REM,       dsel: DV_MIN,  tgt: PC_START};
      4'd8:  cw = '{op: OP_SAVE_MIN,  dsel: DV_MIN,  tgt: PC_START};
      4'd9:  cw = '{op: OP_QUOT,      dsel: DV_WEEK, tgt: PC_START};
      4'd10: cw = '{op: OP_REM,       dsel: DV_WEEK, tgt: PC_START};
      4'd11: cw = '{op: OP_SAVE_WDAY, dsel: DV_WEEK, tgt: PC_START};
      4'd12: cw = '{op: OP_YEAR,      dsel: DV_DAY,  tgt: PC_YEAR};
      4'd13: cw = '{op: OP_MONTH,     dsel: DV_DAY,  tgt: PC_MONTH};
      4'd14: cw = '{op: OP_DONE,      dsel: DV_DAY,  tgt: PC_START};
      default: cw = '{op: OP_DONE, dsel: DV_DAY, tgt: PC_START};
    endcase
    return cw;
  endfunction

  function automatic logic [DIVR_W-1:0] divisor(input dsel_t d);
    logic [DIVR_W-1:0] v;
    case (d)
      DV_DAY:  v = DIVR_W'(86400);
      DV_HOUR: v = DIVR_W'(3600);
      DV_MIN:  v = DIVR_W'(60);
      DV_WEEK: v = DIVR_W'(7);
      default: v = DIVR_W'(86400);
    endcase
    return v;
  endfunction

  function automatic recip_t recip(input dsel_t d);
    recip_t r;
    case (d)
      DV_DAY:  r = '{pre: 3'd7, mul: RECIP_DAY,  post: 6'd36};
      DV_HOUR: r = '{pre: 3'd4, mul: RECIP_HOUR, post: 6'd21};
      DV_MIN:  r = '{pre: 3'd2, mul: RECIP_MIN,  post: 6'd14};
      DV_WEEK: r = '{pre: 3'd0, mul: RECIP_WEEK, post: 6'd19};
      default: r = '{pre: 3'd7, mul: RECIP_DAY,  post: 6'd36};
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    case (m)
      4'd0:  v = 5'd31;
      4'd1:  v = leap ? 5'd29 : 5'd28;
      4'd2:  v = 5'd31;
      4'd3:  v = 5'd30;
      4'd4:  v = 5'd31;
      4'd5:  v = 5'd30;
      4'd6:  v = 5'd31;
      4'd7:  v = 5'd31;
      4'd8:  v = 5'd30;
      4'd9:  v = 5'd31;
      4'd10: v = 5'd30;
      4'd11: v = 5'd31;
      default: v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/gps_seconds_to_utc_calendar.sv
// Top level: GPS seconds to UTC calendar date, driven by a microcoded sequencer.
// Depends on gstuc_pkg (microcode table, divisor, reciprocal and month-length tables).
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: gps_seconds, leap_seconds
//  m_*     | out | m_tvalid/m_tready  | m_tdata: year .. second (one item per input)
//
// Steps: an item is accepted, then runs the reciprocal-divide and bookkeeping steps, a year
//   loop that peels whole years since 1980 and then leaves, a month loop that peels whole
//   months and then leaves, and a finish step; the year loop sets the length of an item.
// Reset: rst (synchronous) returns the sequencer to idle and empties the output register.
// Stalls: a new item is taken while a finished result waits in the output register; the
//   finish step holds until that register is free.
`default_nettype none

module gps_seconds_to_utc_calendar
  import gstuc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // s_tdata from bit 0: gps_seconds[31:0], leap_seconds[38:32], zero pad [39]
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // m_tdata from bit 0: year_since_1900[7:0], month_index[11:8], day_of_month[16:12],
  // day_of_year[25:17], weekday[28:26], hour[33:29], minute[39:34], second[45:40],
  // zero pad [47:46]
  output logic [OUT_W-1:0]      m_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t          state;
  logic [PC_W-1:0] pc;

  // Datapath registers
  logic [ACC_W-1:0] acc;      // running remainder
  logic [QUO_W-1:0] quo;      // quotient of the current division
  logic [QUO_W-1:0] days;     // day count, then days left in the year
  logic [QUO_W-1:0] dtot;     // whole days since 1 Jan 1980
  logic [7:0]       year;     // years since 1980
  logic [3:0]       month;
  logic [8:0]       doy;
  logic [2:0]       wday;
  logic [4:0]       hr;
  logic [5:0]       mn;
  logic [5:0]       sc;

  ctrl_t             cw;
  recip_t            rc;
  logic [RDIV_W-1:0] rdiv;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  qval;
  logic [ACC_W-1:0]  qprod;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic [3:0]        wsum;
  logic              out_free;
  logic              finish;
  logic              accept;
  logic [ACC_W-1:0]  utc;

  assign cw       = ucode(pc);
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == ST_RUN) && (cw.op == OP_DONE) && out_free;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // UTC seconds from 1 Jan 1980; never negative since the offset exceeds any leap count
  assign utc = ACC_W'(s_tdata[GPS_W-1:0]) + UTC_OFFSET
             - ACC_W'(s_tdata[GPS_W +: LEAP_W]);

  // Quotient by reciprocal multiply, then the remainder by subtracting quotient * divisor
  assign rc    = recip(cw.dsel);
  assign rdiv  = RDIV_W'(acc >> rc.pre);
  assign prod  = PROD_W'(rdiv) * PROD_W'(rc.mul);
  assign qval  = QUO_W'(prod >> rc.post);
  assign qprod = ACC_W'(quo) * ACC_W'(divisor(cw.dsel));

  assign ylen = (year[1:0] == 2'b00) ? 9'd366 : 9'd365;
  assign mlen = month_len(month, year[1:0] == 2'b00);
  assign wsum = {1'b0, acc[2:0]} + {1'b0, EPOCH_WDAY};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= PC_START;
      m_tvalid <= 1'b0;
    end else begin
      // load a finished result, else drop the one just taken
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            acc   <= utc;
            pc    <= PC_START;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          case (cw.op)
            OP_QUOT: begin
              quo <= qval;
              pc  <= pc + 1'b1;
            end
            OP_REM: begin
              acc <= acc - qprod;
              pc  <= pc + 1'b1;
            end
            OP_SAVE_DAYS: begin
              days <= quo;
              dtot <= quo;
              pc   <= pc + 1'b1;
            end
            OP_SAVE_HOUR: begin
              hr <= quo[4:0];
              pc <= pc + 1'b1;
            end
            OP_SAVE_MIN: begin
              mn  <= quo[5:0];
              sc  <= acc[5:0];
              acc <= ACC_W'(dtot);   // reuse the divider for the weekday
              pc  <= pc + 1'b1;
            end
            OP_SAVE_WDAY: begin
              wday  <= (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
              year  <= '0;
              month <= '0;
              pc    <= pc + 1'b1;
            end
            OP_YEAR: begin
              // a count equal to the year length rolls into the next year
              if (days < QUO_W'(ylen) || year == YEAR_LIMIT) begin
                doy <= days[8:0];
                pc  <= pc + 1'b1;
              end else begin
                days <= days - QUO_W'(ylen);
                year <= year + 1'b1;
                pc   <= cw.tgt;
              end
            end
            OP_MONTH: begin
              if (month == MONTH_LAST || days < QUO_W'(mlen)) begin
                pc <= pc + 1'b1;
              end else begin
                days  <= days - QUO_W'(mlen);
                month <= month + 1'b1;
                pc    <= cw.tgt;
              end
            end
            OP_DONE: begin
              // hold until the output register is free
              if (out_free) begin
                m_tdata  <= {2'b00, sc, mn, hr, wday, doy, 5'(days + 1'b1), month,
                             8'(year + YEAR_BASE)};
                pc       <= PC_START;
                state    <= ST_IDLE;
              end
            end
            default: begin
              pc    <= PC_START;
              state <= ST_IDLE;
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
          pc    <= PC_START;
        end
      endcase
    end
  end

  // Idle sequencer always sits at the program start
  a_idle_pc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pc == PC_START))
    else $error("sequencer idle away from program start");

  // An accepted item starts the program
  a_accept_run: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN) && (pc == PC_START))
    else $error("accepted item did not start the sequencer");

  // Results leave with fields in range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:8] <= 4'd11) && (m_tdata[28:26] <= 3'd6)
                 && (m_tdata[33:29] <= 5'd23) && (m_tdata[39:34] <= 6'd59)
                 && (m_tdata[45:40] <= 6'd59))
    else $error("result field out of range");

  // Month loop never walks past December
  a_month: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && cw.op == OP_MONTH) |-> (month <= MONTH_LAST))
    else $error("month index past December");

endmodule

`default_nettype wire

// File: dv/tb_gps_seconds_to_utc_calendar.sv
// Self-checking bench for gps_seconds_to_utc_calendar: drives GPS stamps on the input stream
// and checks every calendar item against an in-bench predictor of the conversion.
// Depends on gstuc_pkg (stream widths) and the block under test; reads no files.
`timescale 1ns / 100ps

module tb_gps_seconds_to_utc_calendar;
  import gstuc_pkg::*;

  // Seconds per day and the shift from the GPS epoch to 00:00:00 on 1 January 1980:
  // the 1980 leap count plus the five days from 1 to 6 January.
  localparam int unsigned    SECS_PER_DAY  = 86400;
  localparam longint         UTC_SHIFT     = 19 + 5 * 86400;
  localparam int unsigned    EPOCH_WEEKDAY = 2;     // 1 January 1980 was a Tuesday
  localparam int unsigned    YEARS_TO_1980 = 1980 - 1900;
  localparam int unsigned    YEAR_CAP      = 255;
  localparam int unsigned    LAST_MONTH    = 11;
  localparam int unsigned    FEBRUARY      = 1;
  localparam int unsigned    LAST_YEAR_IDX = 136;   // 2116, the last year a stamp reaches
  localparam int unsigned    MAX_GAP       = 60;    // longest idle run on the input side
  localparam int unsigned    HOLD_OFF      = 1500;  // long output hold-off, in cycles
  localparam int unsigned    DRAIN_CYCLES  = 400;   // beyond the longest item
  localparam longint         CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned    ITEMS_PER_PHASE = 250;

  // One calendar item, field by field
  typedef struct packed {
    logic [7:0] year_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [8:0] day_of_year;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  // s_tdata from bit 0: gps_seconds[31:0], leap_seconds[38:32], zero pad [39]
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  // m_tdata from bit 0: year_since_1900, month_index, day_of_month, day_of_year,
  // weekday, hour, minute, second, zero pad
  logic [OUT_W-1:0] m_tdata;

  cal_t        expected_dates[$];   // predicted dates, oldest first
  int unsigned error_count;
  int unsigned send_idle_pct;       // chance per item slot that the input side idles
  int unsigned recv_stall_pct;      // chance per cycle that the output side stalls
  int unsigned hold_off_left;       // cycles the output side still holds off
  longint      cycle_count;

  gps_seconds_to_utc_calendar DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Every fourth year from 1980 is a leap year, with no century exception.
  function automatic int unsigned days_in_month(input int unsigned m, input bit leap_year);
    int unsigned n;
    case (m)
      FEBRUARY:     n = leap_year ? 29 : 28;
      3, 5, 8, 10:  n = 30;
      default:      n = 31;
    endcase
    return n;
  endfunction

  function automatic cal_t predict_calendar(input logic [31:0] gps, input logic [6:0] leap);
    cal_t        d;
    longint      utc;
    int unsigned days_total, sod, days, yr, mon, mday, ylen;
    utc        = longint'(gps) + UTC_SHIFT - longint'(leap);
    days_total = int'(utc / SECS_PER_DAY);
    sod        = int'(utc % SECS_PER_DAY);
    // Peel whole years; a day count equal to the year length rolls into the next year.
    days = days_total;
    yr   = 0;
    ylen = 366;
    while (days >= ylen && yr < YEAR_CAP) begin
      days = days - ylen;
      yr   = yr + 1;
      ylen = (yr % 4 == 0) ? 366 : 365;
    end
    // Then whole months, stopping at December whatever is left.
    mon  = 0;
    mday = days;
    while (mon < LAST_MONTH && mday >= days_in_month(mon, yr % 4 == 0)) begin
      mday = mday - days_in_month(mon, yr % 4 == 0);
      mon  = mon + 1;
    end
    d.year_since_1900 = 8'(yr + YEARS_TO_1980);
    d.month_index     = 4'(mon);
    d.day_of_month    = 5'(mday + 1);
    d.day_of_year     = 9'(days);
    d.weekday         = 3'((days_total % 7 + EPOCH_WEEKDAY) % 7);
    d.hour            = 5'(sod / 3600);
    d.minute          = 6'((sod % 3600) / 60);
    d.second          = 6'(sod % 60);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one stamp, idling first at random; record the expected date once taken.
  // s_tvalid gets one assignment per edge: low at the start of a gap, high after it.
  task automatic send_stamp(input logic [31:0] gps, input logic [6:0] leap);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({leap, gps});
    do @(posedge clk); while (!s_tready);
    expected_dates.push_back(predict_calendar(gps, leap));
  endtask

  // Send the stamp for a given date and second of day (which may run a few seconds
  // either side of the day). Fall back to a random count where the date lies outside
  // what 32 bits of GPS seconds can express.
  task automatic send_calendar(input int unsigned yr, input int unsigned mon,
                               input int unsigned day_idx, input int sod,
                               input logic [6:0] leap);
    longint utc;
    longint gps_l;
    utc = longint'(yr) * 365 + (yr + 3) / 4;
    for (int unsigned m = 0; m < mon; m++)
      utc += days_in_month(m, yr % 4 == 0);
    // keep the sum signed so that a negative second of day reaches the day before
    utc   = (utc + longint'(day_idx)) * longint'(SECS_PER_DAY) + longint'(sod);
    gps_l = utc - UTC_SHIFT + longint'(leap);
    if (gps_l < 0 || gps_l > 64'hFFFF_FFFF)
      send_stamp($urandom, leap);
    else
      send_stamp(gps_l[31:0], leap);
  endtask

  // Half dates on year, month and day edges with random content, half raw counts.
  task automatic run_random_stamps(input int unsigned n);
    int unsigned yr;
    logic [6:0]  leap;
    for (int unsigned i = 0; i < n; i++) begin
      yr   = $urandom_range(0, LAST_YEAR_IDX);
      leap = 7'($urandom_range(0, 127));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_stamp($urandom, leap);
        // around New Year, either side
        4, 5: send_calendar(yr, 0, 0, int'($urandom_range(0, 6)) - 3, leap);
        // around the start of a month
        6: send_calendar(yr, $urandom_range(0, LAST_MONTH), 0,
                         int'($urandom_range(0, 6)) - 3, leap);
        // 28 or 29 February in a leap year
        7: send_calendar(4 * $urandom_range(0, LAST_YEAR_IDX / 4 - 1), FEBRUARY,
                         $urandom_range(27, 28), $urandom_range(0, SECS_PER_DAY - 1), leap);
        // present-day stamps with realistic leap counts
        8: send_stamp($urandom_range(32'd600_000_000, 32'd2_000_000_000),
                      7'($urandom_range(19, 37)));
        // the last seconds of a day
        default: send_calendar(yr, $urandom_range(0, LAST_MONTH), $urandom_range(0, 27),
                               int'(SECS_PER_DAY - 1 - $urandom_range(0, 2)), leap);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: check each item, then choose the next tready
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  initial begin : result_monitor
    cal_t want;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (expected_dates.size() == 0) begin
          $error("calendar item with no stamp outstanding: %h", m_tdata);
          error_count++;
        end else begin
          want = expected_dates.pop_front();
          check_field("year_since_1900", want.year_since_1900, m_tdata[7:0]);
          check_field("month_index",     want.month_index,     m_tdata[11:8]);
          check_field("day_of_month",    want.day_of_month,    m_tdata[16:12]);
          check_field("day_of_year",     want.day_of_year,     m_tdata[25:17]);
          check_field("weekday",         want.weekday,         m_tdata[28:26]);
          check_field("hour",            want.hour,            m_tdata[33:29]);
          check_field("minute",          want.minute,          m_tdata[39:34]);
          check_field("second",          want.second,          m_tdata[45:40]);
        end
      end
      // Hold off for a long stretch when asked, otherwise stall at random.
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if it has not finished well past the slowest correct run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL gps_seconds_to_utc_calendar");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of both fields, alternating bit patterns, and leap counts above the GPS count
  task automatic test_field_extremes();
    send_stamp(32'd0, 7'd0);
    send_stamp(32'd0, 7'd127);
    send_stamp(32'd0, 7'd19);            // the GPS epoch itself, 6 January 1980
    send_stamp(32'hFFFF_FFFF, 7'd0);     // the latest date, in 2116
    send_stamp(32'hFFFF_FFFF, 7'd127);
    send_stamp(32'h5555_5555, 7'h2A);
    send_stamp(32'hAAAA_AAAA, 7'h55);
    send_stamp(32'd5, 7'd100);           // leap count larger than the GPS count
    send_stamp(32'd126, 7'd127);
  endtask

  // New Year's day roll-over, leap days, year ends and the four-year rule past 2099
  task automatic test_calendar_edges();
    send_calendar(0, LAST_MONTH, 30, SECS_PER_DAY - 1, 7'd19);  // 31 Dec 1980, day 365
    send_calendar(1, 0, 0, 0, 7'd19);                           // 1 Jan 1981
    send_calendar(4, FEBRUARY, 28, 43200, 7'd23);               // 29 Feb 1984
    send_calendar(4, 2, 0, 0, 7'd23);                           // 1 Mar 1984
    send_calendar(19, LAST_MONTH, 30, SECS_PER_DAY - 1, 7'd32); // 31 Dec 1999
    send_calendar(20, 0, 0, 0, 7'd32);                          // 1 Jan 2000
    send_calendar(43, FEBRUARY, 27, SECS_PER_DAY - 1, 7'd37);   // 28 Feb 2023
    send_calendar(43, 2, 0, 0, 7'd37);                          // 1 Mar 2023
    send_calendar(120, FEBRUARY, 28, 0, 7'd37);                 // 29 Feb 2100
    send_calendar(120, LAST_MONTH, 30, 3599, 7'd37);            // 31 Dec 2100, day 365
    send_calendar(121, 0, 0, 0, 7'd37);                         // 1 Jan 2101
  endtask

  task automatic test_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_stamps(ITEMS_PER_PHASE);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 81;
    recv_stall_pct = 0;
    run_random_stamps(ITEMS_PER_PHASE);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    run_random_stamps(ITEMS_PER_PHASE);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    run_random_stamps(ITEMS_PER_PHASE);
  endtask

  // Hold the output off for a long stretch while stamps keep coming, so that the
  // result register fills and the input side is throttled.
  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = HOLD_OFF;
    run_random_stamps(40);
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_calendar_edges();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_output_hold_off();

    // Drop valid, drain what is still in flight, then watch for stray items.
    s_tvalid       <= 1'b0;
    recv_stall_pct = 0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS gps_seconds_to_utc_calendar");
    end else begin
      $display("FAIL gps_seconds_to_utc_calendar");
    end
    $finish;
  end

endmodule
